>>> design/bse_pkg.sv
// Shared constants, opcodes and bit search functions for the bitmap set engine.
`default_nettype none

package bse_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ELEMENT = 1024;
    localparam int DEF_WORD_BITS   = 32;

    // Fixed field widths.
    localparam int OP_W     = 4;
    localparam int ELEM_W   = 11;
    localparam int FOUND_W  = 11;
    localparam int HOLDER_W = 2;

    // Widest word the bit search functions handle, and the width of a bit index in it.
    localparam int MAX_WORD_W = 64;
    localparam int BIT_IDX_W  = 7;

    // Fixed-point shift used for the reciprocal that splits an element into word and bit.
    localparam int RECIP_SHIFT = 20;

    localparam logic [OP_W-1:0] OP_INSERT    = 4'd0;
    localparam logic [OP_W-1:0] OP_DELETE    = 4'd1;
    localparam logic [OP_W-1:0] OP_MEMBER    = 4'd2;
    localparam logic [OP_W-1:0] OP_MIN       = 4'd3;
    localparam logic [OP_W-1:0] OP_MAX       = 4'd4;
    localparam logic [OP_W-1:0] OP_UNION     = 4'd5;
    localparam logic [OP_W-1:0] OP_INTERSECT = 4'd6;
    localparam logic [OP_W-1:0] OP_DIFF      = 4'd7;
    localparam logic [OP_W-1:0] OP_EQUAL     = 4'd8;
    localparam logic [OP_W-1:0] OP_COPY      = 4'd9;
    localparam logic [OP_W-1:0] OP_FIND      = 4'd10;

    localparam logic [HOLDER_W-1:0] HOLD_NONE = 2'd0;
    localparam logic [HOLDER_W-1:0] HOLD_A    = 2'd1;
    localparam logic [HOLDER_W-1:0] HOLD_B    = 2'd2;

    // Index of the highest set bit; zero for an empty word.
    function automatic logic [BIT_IDX_W-1:0] hi_bit(input logic [MAX_WORD_W-1:0] w);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < MAX_WORD_W; i++)
        begin
            if (w[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

    // Index of the lowest set bit; zero for an empty word.
    function automatic logic [BIT_IDX_W-1:0] lo_bit(input logic [MAX_WORD_W-1:0] w);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = MAX_WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

>>> design/bse_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/bitmap_set_engine.sv
// Top level of the bitmap set engine: two bitmap sets kept in word memories.
`default_nettype none

// Channel   Handshake              Payload
// --------  ---------------------  ------------------------------------------
// request   req_valid / req_stall  opcode, target_set, element
// response  rsp_valid / rsp_stall  found_value, answer_flag, holder, status
//
// An element operation (insert, delete, member, find) passes from acceptance
// through ST_DIV, ST_RD, ST_MOD and ST_DONE to the result register: split the
// element, read, then modify and write (insert and delete only). Set-wide
// operations and min/max walk all NWORDS words, one word per cycle through the
// read port. Bad elements and unused opcodes go straight to ST_DONE.
// After reset both memories are cleared, one word per cycle, while req_stall
// stays high. The result sits in an output register; a stalled response holds
// the engine in its final state until the register is taken.

module bitmap_set_engine
    import bse_pkg::*;
#(
    parameter int MAX_ELEMENT = DEF_MAX_ELEMENT,
    parameter int WORD_BITS   = DEF_WORD_BITS
)(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [OP_W-1:0]     opcode,
    input  wire logic                target_set,
    input  wire logic [ELEM_W-1:0]   element,

    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic [FOUND_W-1:0]       found_value,
    output logic                     answer_flag,
    output logic [HOLDER_W-1:0]      holder,
    output logic                     status
);

    // Memory geometry.
    localparam int NWORDS = (MAX_ELEMENT + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST   = NWORDS - 1;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CW     = $clog2(NWORDS + 1);
    localparam int BW     = $clog2(WORD_BITS);
    localparam int CALC_W = $clog2(NWORDS * WORD_BITS + 1);

    // Reciprocal of WORD_BITS, rounded up; exact for every 11-bit element.
    localparam int RECIP = (2 ** RECIP_SHIFT + WORD_BITS - 1) / WORD_BITS;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_MOD   = 3'd4;
    localparam logic [2:0] ST_WALK  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Control registers.
    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 dv_reg, dv_next;
    logic                 dlast_reg, dlast_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Payload registers.
    logic [OP_W-1:0]      op_reg, op_next;
    logic                 tset_reg, tset_next;
    logic [ELEM_W-1:0]    elem_reg, elem_next;
    logic                 bad_reg, bad_next;
    logic [ELEM_W-1:0]    q_reg, q_next;
    logic [WORD_BITS-1:0] mask_reg, mask_next;
    logic [AW-1:0]        didx_reg, didx_next;
    logic [FOUND_W-1:0]   res_found_reg, res_found_next;
    logic                 res_flag_reg, res_flag_next;
    logic [HOLDER_W-1:0]  res_holder_reg, res_holder_next;
    logic [FOUND_W-1:0]   found_value_reg, found_value_next;
    logic                 answer_flag_reg, answer_flag_next;
    logic [HOLDER_W-1:0]  holder_reg, holder_next;
    logic                 status_reg, status_next;

    // Memory ports.
    logic                 wr_en_a, wr_en_b;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data_a, wr_data_b;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data_a, rd_data_b;

    // Datapath helpers.
    logic                 needs_elem;
    logic                 elem_bad;
    logic [ELEM_W-1:0]    k_val;
    logic [31:0]          recip_prod;
    logic [ELEM_W-1:0]    rem_val;
    logic [BW-1:0]        bit_shift;
    logic [AW-1:0]        q_addr;
    logic [AW-1:0]        walk_addr;
    logic                 walk_issue;
    logic [WORD_BITS-1:0] t_word;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic [CALC_W-1:0]    found_calc;
    logic                 a_hit, b_hit;
    logic                 rsp_free;

    bse_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data_a),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_a)
    );

    bse_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data_b),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_b)
    );

    // Only insert, delete, member and find look at the element field.
    assign needs_elem = (opcode == OP_INSERT) || (opcode == OP_DELETE) ||
                        (opcode == OP_MEMBER) || (opcode == OP_FIND);
    assign elem_bad   = needs_elem &&
                        ((element == '0) || (32'(element) > MAX_ELEMENT));

    // Element e lives in word (e-1)/WORD_BITS, counted from the top bit of the word.
    // The quotient comes from a reciprocal multiply, the remainder in the following cycle from the registered quotient.
    assign k_val      = elem_reg - ELEM_W'(1);
    assign recip_prod = 32'(k_val) * 32'(RECIP);
    assign rem_val    = k_val - ELEM_W'(32'(q_reg) * 32'(WORD_BITS));
    assign bit_shift  = BW'(WORD_BITS - 1) - BW'(rem_val);
    assign q_addr     = AW'(q_reg);

    // Max walks the words from the top down so the first hit is the answer.
    assign walk_issue = (cnt_reg < CW'(NWORDS));
    assign walk_addr  = (op_reg == OP_MAX) ? (AW'(LAST) - cnt_reg[AW-1:0])
                                           : cnt_reg[AW-1:0];

    assign t_word = tset_reg ? rd_data_b : rd_data_a;
    assign a_hit  = |(rd_data_a & mask_reg);
    assign b_hit  = |(rd_data_b & mask_reg);

    // The smallest member is the highest set bit of the first nonzero word,
    // the largest is the lowest set bit of the last one; both give the same formula.
    assign bit_pos    = (op_reg == OP_MIN) ? hi_bit(MAX_WORD_W'(t_word))
                                           : lo_bit(MAX_WORD_W'(t_word));
    assign found_calc = CALC_W'(didx_reg) * CALC_W'(WORD_BITS) + CALC_W'(WORD_BITS)
                        - CALC_W'(bit_pos);

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);

    // Memory control.
    always_comb
    begin
        wr_en_a   = 1'b0;
        wr_en_b   = 1'b0;
        wr_addr   = didx_reg;
        wr_data_a = '0;
        wr_data_b = '0;
        rd_en     = 1'b0;
        rd_addr   = walk_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en_a = 1'b1;
                wr_en_b = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
            end
            ST_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = q_addr;
            end
            ST_MOD:
            begin
                wr_addr = q_addr;
                if ((op_reg == OP_INSERT) || (op_reg == OP_DELETE))
                begin
                    wr_en_a = !tset_reg;
                    wr_en_b = tset_reg;
                end
                if (op_reg == OP_INSERT)
                begin
                    wr_data_a = rd_data_a | mask_reg;
                    wr_data_b = rd_data_b | mask_reg;
                end
                else
                begin
                    wr_data_a = rd_data_a & ~mask_reg;
                    wr_data_b = rd_data_b & ~mask_reg;
                end
            end
            ST_WALK:
            begin
                rd_en = walk_issue;
                // Write-back lands one word behind the read, so it never hits the
                // entry being read in the same cycle.
                if (dv_reg)
                begin
                    unique case (op_reg)
                        OP_UNION:
                        begin
                            wr_en_a   = 1'b1;
                            wr_data_a = rd_data_a | rd_data_b;
                        end
                        OP_INTERSECT:
                        begin
                            wr_en_a   = 1'b1;
                            wr_data_a = rd_data_a & rd_data_b;
                        end
                        OP_DIFF:
                        begin
                            wr_en_a   = 1'b1;
                            wr_data_a = rd_data_a & ~rd_data_b;
                        end
                        OP_COPY:
                        begin
                            wr_en_a   = 1'b1;
                            wr_data_a = rd_data_b;
                        end
                        default:
                        begin
                            wr_en_a = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer and result collection.
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        dv_next          = 1'b0;
        dlast_next       = 1'b0;
        rsp_valid_next   = rsp_valid_reg;
        op_next          = op_reg;
        tset_next        = tset_reg;
        elem_next        = elem_reg;
        bad_next         = bad_reg;
        q_next           = q_reg;
        mask_next        = mask_reg;
        didx_next        = didx_reg;
        res_found_next   = res_found_reg;
        res_flag_next    = res_flag_reg;
        res_holder_next  = res_holder_reg;
        found_value_next = found_value_reg;
        answer_flag_next = answer_flag_reg;
        holder_next      = holder_reg;
        status_next      = status_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CW'(LAST))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = opcode;
                    tset_next       = target_set;
                    elem_next       = element;
                    bad_next        = elem_bad;
                    cnt_next        = '0;
                    res_found_next  = '0;
                    res_flag_next   = (opcode == OP_EQUAL);
                    res_holder_next = HOLD_NONE;
                    if (elem_bad)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (needs_elem)
                    begin
                        state_next = ST_DIV;
                    end
                    else if ((opcode >= OP_MIN) && (opcode <= OP_COPY))
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                q_next     = ELEM_W'(recip_prod >> RECIP_SHIFT);
                state_next = ST_RD;
            end
            ST_RD:
            begin
                mask_next  = WORD_BITS'(1) << bit_shift;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (op_reg == OP_MEMBER)
                begin
                    res_flag_next = tset_reg ? b_hit : a_hit;
                end
                if (op_reg == OP_FIND)
                begin
                    if (a_hit)
                    begin
                        res_holder_next = HOLD_A;
                    end
                    else if (b_hit)
                    begin
                        res_holder_next = HOLD_B;
                    end
                end
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                if (walk_issue)
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    dv_next    = 1'b1;
                    didx_next  = walk_addr;
                    dlast_next = (cnt_reg == CW'(LAST));
                end
                if (dv_reg)
                begin
                    if ((op_reg == OP_EQUAL) && (rd_data_a != rd_data_b))
                    begin
                        res_flag_next = 1'b0;
                    end
                    if (((op_reg == OP_MIN) || (op_reg == OP_MAX)) &&
                        !res_flag_reg && (t_word != '0))
                    begin
                        res_flag_next  = 1'b1;
                        res_found_next = FOUND_W'(found_calc);
                    end
                    if (dlast_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    found_value_next = res_found_reg;
                    answer_flag_next = res_flag_reg;
                    holder_next      = res_holder_reg;
                    status_next      = bad_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            dlast_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dv_reg        <= dv_next;
            dlast_reg     <= dlast_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        tset_reg        <= tset_next;
        elem_reg        <= elem_next;
        bad_reg         <= bad_next;
        q_reg           <= q_next;
        mask_reg        <= mask_next;
        didx_reg        <= didx_next;
        res_found_reg   <= res_found_next;
        res_flag_reg    <= res_flag_next;
        res_holder_reg  <= res_holder_next;
        found_value_reg <= found_value_next;
        answer_flag_reg <= answer_flag_next;
        holder_reg      <= holder_next;
        status_reg      <= status_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found_value = found_value_reg;
    assign answer_flag = answer_flag_reg;
    assign holder      = holder_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire
